### hw/rtl/dlpid_pkg.sv
// ---------------------------------------------------------------------------
// dlpid_pkg: shared types and constants for the dual-loop PID controller
// Register map, request and mode codes, microcode format and program.
// ---------------------------------------------------------------------------
package dlpid_pkg;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register indexes in the configuration map.
  localparam logic [2:0] REG_CUR_KP    = 3'd0;
  localparam logic [2:0] REG_CUR_KI    = 3'd1;
  localparam logic [2:0] REG_CUR_KD    = 3'd2;
  localparam logic [2:0] REG_TEMP_KP   = 3'd3;
  localparam logic [2:0] REG_TEMP_KI   = 3'd4;
  localparam logic [2:0] REG_TEMP_KD   = 3'd5;
  localparam logic [2:0] REG_DRIVE_MAX = 3'd6;
  localparam logic [2:0] REG_DRIVE_MIN = 3'd7;

  // Request codes; the unused code behaves as a tick.
  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_ENABLE  = 2'd1;
  localparam logic [1:0] REQ_DISABLE = 2'd2;

  // Loop mode codes as seen on the result.
  localparam logic [1:0] LOOP_MODE_SLEEP = 2'd0;
  localparam logic [1:0] LOOP_MODE_CUR   = 2'd1;
  localparam logic [1:0] LOOP_MODE_TEMP  = 2'd2;

  // Drive value after an enable command and after reset.
  localparam logic [15:0] IDLE_OUTPUT = 16'd0;

  // Mode-switch threshold on the temperature error, 5.0 in Q16.16.
  localparam logic signed [31:0] FIVE_Q16     = 32'sd327680;
  localparam logic signed [31:0] NEG_FIVE_Q16 = -32'sd327680;

  // Sequencer step counter.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] LAST_STEP = 3'd7;

  typedef struct packed {
    logic signed [31:0] cur_kp;
    logic [31:0]        cur_ki;
    logic [31:0]        cur_kd;
    logic signed [31:0] temp_kp;
    logic [31:0]        temp_ki;
    logic [31:0]        temp_kd;
    logic [15:0]        drive_max;
    logic [15:0]        drive_min;
  } cfg_t;

  // Controller mode, one-hot.
  typedef enum logic [2:0] {
    MODE_SLEEP = 3'b001,
    MODE_CUR   = 3'b010,
    MODE_TEMP  = 3'b100
  } mode_t;

  // Operand pair that the shared multiplier works on in a step.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERR_KI,
    MUL_DIFF_KD,
    MUL_KP_LO,
    MUL_KP_HI
  } mul_op_t;

  // One microcode word.
  typedef struct packed {
    mul_op_t mul_op;
    logic    ld_acc;
    logic    ld_sum;
    logic    ld_tlo;
    logic    exit_bypass;
    logic    finish;
  } ucode_t;

  // Datapath controls issued by the sequencer in the current cycle.
  typedef struct packed {
    mul_op_t mul_op;
    logic    ld_acc;
    logic    ld_sum;
    logic    ld_tlo;
    logic    fin_cmd;
    logic    fin_loop;
  } dp_ctrl_t;

  // Microcode program. Step 0 leaves early for commands and for requests
  // that run no loop; steps 1 to 7 run one PID update.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{mul_op: MUL_NONE, default: 1'b0};
    case (step)
      3'd0: w.exit_bypass = 1'b1;
      3'd1: w.mul_op = MUL_ERR_KI;
      3'd2: w.ld_acc = 1'b1;
      3'd3: w.mul_op = MUL_DIFF_KD;
      3'd4: w.ld_sum = 1'b1;
      3'd5: w.mul_op = MUL_KP_LO;
      3'd6: begin
        w.mul_op = MUL_KP_HI;
        w.ld_tlo = 1'b1;
      end
      3'd7: w.finish = 1'b1;
      default: w.finish = 1'b1;
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/dual_loop_pid_with_mode_switch.sv
// ---------------------------------------------------------------------------
// dual_loop_pid_with_mode_switch: current/temperature PID with mode switch
// A tick that runs a loop walks the eight microcode steps through the one
// multiplier before its result is registered; commands and ticks that run
// no loop leave at the first step. A new request is taken only once the
// last one is finished; the final step stalls while the result is still held.
// Reset: synchronous; mode sleep, loop state cleared, held drive at idle value.
// ---------------------------------------------------------------------------
module dual_loop_pid_with_mode_switch (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        req_type,
  input  logic signed [31:0]                current_meas,
  input  logic signed [31:0]                temp_meas,
  input  logic signed [31:0]                current_target,
  input  logic signed [31:0]                temp_target,
  input  logic                              current_loop_enable,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       drive_value,
  output logic [1:0]                        loop_mode,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dlpid_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [dlpid_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [dlpid_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready
);
  import dlpid_pkg::*;

  cfg_t        cfg;
  dp_ctrl_t    ctrl;
  logic        busy;
  logic        start;
  logic        bypass;
  logic        out_free;
  logic [15:0] drive_next;
  logic [1:0]  loop_mode_next;

  // A new request is taken whenever the sequencer is idle.
  assign in_ready = !busy;
  assign start    = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  dlpid_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dlpid_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .bypass   (bypass),
    .out_free (out_free),
    .busy     (busy),
    .ctrl     (ctrl)
  );

  dlpid_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .req_type            (req_type),
    .current_meas        (current_meas),
    .temp_meas           (temp_meas),
    .current_target      (current_target),
    .temp_target         (temp_target),
    .current_loop_enable (current_loop_enable),
    .cfg                 (cfg),
    .ctrl                (ctrl),
    .bypass              (bypass),
    .drive_next          (drive_next),
    .loop_mode_next      (loop_mode_next)
  );

  // Result register between the datapath and the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fin_cmd || ctrl.fin_loop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin_cmd || ctrl.fin_loop) begin
      drive_value <= drive_next;
      loop_mode   <= loop_mode_next;
    end
  end

endmodule

### hw/rtl/dlpid_regs.sv
// ---------------------------------------------------------------------------
// dlpid_regs: configuration register file
// APB-style slave holding the loop gains and the drive limits.
// ---------------------------------------------------------------------------
module dlpid_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dlpid_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [dlpid_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [dlpid_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  output dlpid_pkg::cfg_t                     cfg
);
  import dlpid_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // Register writes in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cur_kp    <= '0;
      cfg.cur_ki    <= '0;
      cfg.cur_kd    <= '0;
      cfg.temp_kp   <= '0;
      cfg.temp_ki   <= '0;
      cfg.temp_kd   <= '0;
      cfg.drive_max <= 16'hFFFF;
      cfg.drive_min <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CUR_KP:    cfg.cur_kp    <= pwdata;
        REG_CUR_KI:    cfg.cur_ki    <= pwdata;
        REG_CUR_KD:    cfg.cur_kd    <= pwdata;
        REG_TEMP_KP:   cfg.temp_kp   <= pwdata;
        REG_TEMP_KI:   cfg.temp_ki   <= pwdata;
        REG_TEMP_KD:   cfg.temp_kd   <= pwdata;
        REG_DRIVE_MAX: cfg.drive_max <= pwdata[15:0];
        REG_DRIVE_MIN: cfg.drive_min <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      REG_CUR_KP:    prdata = cfg.cur_kp;
      REG_CUR_KI:    prdata = cfg.cur_ki;
      REG_CUR_KD:    prdata = cfg.cur_kd;
      REG_TEMP_KP:   prdata = cfg.temp_kp;
      REG_TEMP_KI:   prdata = cfg.temp_ki;
      REG_TEMP_KD:   prdata = cfg.temp_kd;
      REG_DRIVE_MAX: prdata = {16'd0, cfg.drive_max};
      REG_DRIVE_MIN: prdata = {16'd0, cfg.drive_min};
      default:       prdata = '0;
    endcase
  end

endmodule

### hw/rtl/dlpid_seq.sv
// ---------------------------------------------------------------------------
// dlpid_seq: microcode sequencer
// Step counter over the microcode program, with an early exit and a stall
// of the final step while the result register is still occupied.
// ---------------------------------------------------------------------------
module dlpid_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                bypass,
  input  logic                out_free,
  output logic                busy,
  output dlpid_pkg::dp_ctrl_t ctrl
);
  import dlpid_pkg::*;

  logic [STEP_W-1:0] step;
  ucode_t            word;
  logic              at_end;
  logic              fin;

  assign word   = ucode_rom(step);
  assign at_end = (word.exit_bypass && bypass) || word.finish;
  assign fin    = ctrl.fin_cmd || ctrl.fin_loop;

  // Controls for the datapath, active only while a request is in work.
  always_comb begin
    ctrl.mul_op   = busy ? word.mul_op : MUL_NONE;
    ctrl.ld_acc   = busy && word.ld_acc;
    ctrl.ld_sum   = busy && word.ld_sum;
    ctrl.ld_tlo   = busy && word.ld_tlo;
    ctrl.fin_cmd  = busy && word.exit_bypass && bypass && out_free;
    ctrl.fin_loop = busy && word.finish && out_free;
  end

  // Step counter: advance, or leave the program once the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (at_end) begin
        if (out_free) begin
          busy <= 1'b0;
        end
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    fin |=> !busy)
    else $error("sequencer still busy after finishing a request");

  a_start_step0: assert property (@(posedge clk) disable iff (rst)
    start |=> (busy && step == '0))
    else $error("request did not start the program at its first step");

  a_loop_last: assert property (@(posedge clk) disable iff (rst)
    ctrl.fin_loop |-> (step == LAST_STEP && $past(ctrl.ld_tlo || !busy || ctrl.fin_loop
      || word.finish)))
    else $error("loop result committed outside the last step");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && at_end && !out_free) |=> (busy && $stable(step)))
    else $error("final step did not hold while the result register was full");

endmodule

### hw/rtl/dlpid_dp.sv
// ---------------------------------------------------------------------------
// dlpid_dp: controller datapath
// Captured request, loop state, shared 33x33 multiplier and the saturating
// drive logic, all steered by the sequencer controls.
// ---------------------------------------------------------------------------
module dlpid_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          req_type,
  input  logic signed [31:0]  current_meas,
  input  logic signed [31:0]  temp_meas,
  input  logic signed [31:0]  current_target,
  input  logic signed [31:0]  temp_target,
  input  logic                current_loop_enable,
  input  dlpid_pkg::cfg_t     cfg,
  input  dlpid_pkg::dp_ctrl_t ctrl,
  output logic                bypass,
  output logic [15:0]         drive_next,
  output logic [1:0]          loop_mode_next
);
  import dlpid_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    if (v[48] != v[47]) begin
      return v[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    end
    return v[47:0];
  endfunction

  // Captured request.
  logic [1:0]         req_q;
  logic               en_q;
  logic signed [31:0] ce_q;
  logic signed [31:0] te_q;

  // Loop state.
  mode_t              mode;
  mode_t              mode_new;
  logic signed [47:0] cur_accum;
  logic signed [47:0] temp_accum;
  logic signed [31:0] cur_prev;
  logic signed [31:0] temp_prev;
  logic [15:0]        held_drive;
  logic [15:0]        held_new;

  // Working registers.
  logic signed [65:0] prod_q;
  logic signed [31:0] diff_q;
  logic signed [49:0] s_q;
  logic signed [31:0] tlo_q;

  // Selected loop.
  logic               use_temp;
  logic signed [31:0] e_sel;
  logic signed [31:0] kp_sel;
  logic [31:0]        ki_sel;
  logic [31:0]        kd_sel;
  logic signed [47:0] accum_sel;
  logic signed [31:0] prev_sel;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [47:0] prod_shr;
  logic signed [47:0] acc_new;
  logic signed [31:0] diff_new;
  logic signed [49:0] s_new;
  logic signed [50:0] yh;
  logic [15:0]        loop_drive;
  logic               te_small;

  // Capture the request and form both saturated errors.
  always_ff @(posedge clk) begin
    if (start) begin
      req_q <= req_type;
      en_q  <= current_loop_enable;
      ce_q  <= sat32({current_target[31], current_target} - {current_meas[31], current_meas});
      te_q  <= sat32({temp_target[31], temp_target} - {temp_meas[31], temp_meas});
    end
  end

  assign te_small = (te_q < FIVE_Q16) && (te_q > NEG_FIVE_Q16);
  assign bypass   = (req_q == REQ_ENABLE) || (req_q == REQ_DISABLE) ||
                    (mode == MODE_SLEEP) || (mode == MODE_CUR && !en_q);

  // Loop selection follows the mode, which holds until the result commits.
  assign use_temp  = (mode == MODE_TEMP);
  assign e_sel     = use_temp ? te_q        : ce_q;
  assign kp_sel    = use_temp ? cfg.temp_kp : cfg.cur_kp;
  assign ki_sel    = use_temp ? cfg.temp_ki : cfg.cur_ki;
  assign kd_sel    = use_temp ? cfg.temp_kd : cfg.cur_kd;
  assign accum_sel = use_temp ? temp_accum  : cur_accum;
  assign prev_sel  = use_temp ? temp_prev   : cur_prev;

  // Shared multiplier operands.
  always_comb begin
    case (ctrl.mul_op)
      MUL_ERR_KI: begin
        mul_a = {e_sel[31], e_sel};
        mul_b = {1'b0, ki_sel};
      end
      MUL_DIFF_KD: begin
        mul_a = {diff_q[31], diff_q};
        mul_b = {1'b0, kd_sel};
      end
      MUL_KP_LO: begin
        mul_a = {kp_sel[31], kp_sel};
        mul_b = {1'b0, s_q[31:0]};
      end
      MUL_KP_HI: begin
        mul_a = {kp_sel[31], kp_sel};
        mul_b = {{15{s_q[49]}}, s_q[49:32]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_op != MUL_NONE) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // Floor of the product over 2^16; the products here stay within 64 bits.
  assign prod_shr = prod_q[63:16];
  assign acc_new  = sat48({accum_sel[47], accum_sel} + {prod_shr[47], prod_shr});
  assign diff_new = sat32({e_sel[31], e_sel} - {prev_sel[31], prev_sel});
  assign s_new    = {{18{e_sel[31]}}, e_sel} + {{2{accum_sel[47]}}, accum_sel}
                  + {{2{prod_shr[47]}}, prod_shr};

  // Integer part of kp * s: high partial product plus the carried low part.
  assign yh = {prod_q[49], prod_q[49:0]} + {{19{tlo_q[31]}}, tlo_q};

  // Saturation: a negative result goes to the lower limit.
  always_comb begin
    if (yh[50]) begin
      loop_drive = cfg.drive_min;
    end else if (yh > {35'd0, cfg.drive_max}) begin
      loop_drive = cfg.drive_max;
    end else if (yh < {35'd0, cfg.drive_min}) begin
      loop_drive = cfg.drive_min;
    end else begin
      loop_drive = yh[15:0];
    end
  end

  // Working registers for the loop steps.
  always_ff @(posedge clk) begin
    if (ctrl.ld_acc) begin
      diff_q <= diff_new;
    end
    if (ctrl.ld_sum) begin
      s_q <= s_new;
    end
    if (ctrl.ld_tlo) begin
      tlo_q <= prod_q[63:32];
    end
  end

  // Drive and mode committed with the result.
  always_comb begin
    held_new = held_drive;
    mode_new = mode;
    if (ctrl.fin_cmd) begin
      if (req_q == REQ_ENABLE) begin
        held_new = IDLE_OUTPUT;
        mode_new = MODE_CUR;
      end else if (req_q == REQ_DISABLE) begin
        held_new = 16'd0;
        mode_new = MODE_SLEEP;
      end else if (mode == MODE_CUR) begin
        mode_new = MODE_TEMP;
      end
    end else if (ctrl.fin_loop) begin
      held_new = loop_drive;
      if (mode == MODE_CUR && te_small) begin
        mode_new = MODE_TEMP;
      end else if (mode == MODE_TEMP && !te_small && en_q) begin
        mode_new = MODE_CUR;
      end
    end
  end

  assign drive_next = held_new;

  always_comb begin
    case (mode_new)
      MODE_SLEEP: loop_mode_next = LOOP_MODE_SLEEP;
      MODE_CUR:   loop_mode_next = LOOP_MODE_CUR;
      MODE_TEMP:  loop_mode_next = LOOP_MODE_TEMP;
      default:    loop_mode_next = LOOP_MODE_SLEEP;
    endcase
  end

  // Persistent controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_SLEEP;
      held_drive <= IDLE_OUTPUT;
      cur_accum  <= '0;
      temp_accum <= '0;
      cur_prev   <= '0;
      temp_prev  <= '0;
    end else begin
      mode       <= mode_new;
      held_drive <= held_new;
      if (ctrl.fin_cmd && (req_q == REQ_ENABLE || req_q == REQ_DISABLE)) begin
        cur_accum  <= '0;
        temp_accum <= '0;
        cur_prev   <= '0;
        temp_prev  <= '0;
      end else begin
        if (ctrl.ld_acc) begin
          if (use_temp) begin
            temp_accum <= acc_new;
          end else begin
            cur_accum <= acc_new;
          end
        end
        if (ctrl.ld_sum) begin
          if (use_temp) begin
            temp_prev <= e_sel;
          end else begin
            cur_prev <= e_sel;
          end
        end
      end
    end
  end

endmodule
